FILE: hw/rtl/srv_rx_pkg.sv
package srv_rx_pkg;

	localparam int PhaseWidth = 3;

	localparam logic [PhaseWidth-1:0] PH_IDLE  = 3'd0;
	localparam logic [PhaseWidth-1:0] PH_SYNC1 = 3'd1;
	localparam logic [PhaseWidth-1:0] PH_LEN   = 3'd2;
	localparam logic [PhaseWidth-1:0] PH_INSTR = 3'd3;
	localparam logic [PhaseWidth-1:0] PH_BODY  = 3'd4;

	localparam logic [7:0] SYNC_BYTE = 8'hff;
	localparam logic [7:0] LEN_DROP  = 8'hff;
	localparam logic [7:0] LEN_MIN   = 8'd2;

	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] param_byte;
		logic [7:0] param_index;
		logic [7:0] opcode;
		logic [7:0] frame_length;
		logic       checksum_ok;
		logic       last;
	} srv_result_t;

endpackage

FILE: hw/rtl/servo_packet_receiver.sv
// Deframes servo packets of the form FF FF length instruction params checksum from a byte
// stream, one byte per cycle with no bubbles while the output is not stalled. Each
// parameter byte comes out as one transaction with its index; the checksum byte ends the
// frame with a transaction carrying instruction, length and a checksum match flag (one's
// complement of the 8-bit sum of length, instruction and parameters). Lengths of 255 or
// below 2 drop the frame silently; length 2 means no parameters. An accepted byte passes
// through the input register, then the deframer state and result logic, which load the
// output register when it is not held by an output stall.
module servo_packet_receiver
	import srv_rx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] param_byte,
	output logic [7:0] param_index,
	output logic [7:0] opcode,
	output logic [7:0] frame_length,
	output logic       checksum_ok,
	output logic       last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	srv_result_t out_q;
	logic        advance;
	logic        res_valid;
	srv_result_t res;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	srv_rx_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign param_byte   = out_q.param_byte;
	assign param_index  = out_q.param_index;
	assign opcode       = out_q.opcode;
	assign frame_length = out_q.frame_length;
	assign checksum_ok  = out_q.checksum_ok;
	assign last         = out_q.last;

endmodule

FILE: hw/rtl/srv_rx_deframer.sv
module srv_rx_deframer
	import srv_rx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	output srv_result_t res
);

	logic [PhaseWidth-1:0] phase_q;
	logic [7:0]            length_q;
	logic [7:0]            count_q;
	logic [7:0]            opcode_q;
	logic [7:0]            sum_q;

	logic [PhaseWidth-1:0] phase_d;
	logic [7:0]            length_d;
	logic [7:0]            count_d;
	logic [7:0]            opcode_d;
	logic [7:0]            sum_d;
	logic [8:0]            count_ext;
	logic                  at_checksum;

	assign count_ext   = {1'b0, count_q} + 9'd2;
	assign at_checksum = count_ext >= {1'b0, length_q};

	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		count_d   = count_q;
		opcode_d  = opcode_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res.kind         = KIND_PARAM;
		res.param_byte   = 8'd0;
		res.param_index  = 8'd0;
		res.opcode       = opcode_q;
		res.frame_length = length_q;
		res.checksum_ok  = 1'b0;
		res.last         = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte == SYNC_BYTE) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_SYNC1: begin
				phase_d = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_IDLE;
			end
			PH_LEN: begin
				length_d = rx_byte;
				sum_d    = rx_byte;
				phase_d  = (rx_byte == LEN_DROP || rx_byte < LEN_MIN) ? PH_IDLE : PH_INSTR;
			end
			PH_INSTR: begin
				opcode_d = rx_byte;
				sum_d    = sum_q + rx_byte;
				count_d  = 8'd0;
				phase_d  = PH_BODY;
			end
			PH_BODY: begin
				res_valid = 1'b1;
				if (at_checksum) begin
					res.kind        = KIND_END;
					res.checksum_ok = (rx_byte == ~sum_q);
					res.last        = 1'b1;
					phase_d         = PH_IDLE;
				end else begin
					res.param_byte  = rx_byte;
					res.param_index = count_q;
					sum_d           = sum_q + rx_byte;
					count_d         = count_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			length_q <= 8'd0;
			count_q  <= 8'd0;
			opcode_q <= 8'd0;
			sum_q    <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			count_q  <= count_d;
			opcode_q <= opcode_d;
			sum_q    <= sum_d;
		end
	end

endmodule

FILE: tb/tb_top.sv
module tb_top;
	import srv_rx_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int TargetBytes   = 1850;
	localparam int MaxWait       = 12;

	typedef struct packed {
		logic [7:0]  data;
		logic        pinned;
		logic        has_res;
		srv_result_t res;
	} row_t;

	localparam srv_result_t NO_RES = '0;

	// pinned rows carry their expected transaction; the rest go through the predictor
	localparam row_t DIRECTED [27] = '{
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'h01, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'h02, 1'b1, 1'b0, NO_RES},
		'{8'h7f, 1'b1, 1'b0, NO_RES},
		'{8'h7e, 1'b1, 1'b1, '{KIND_END, 8'h00, 8'h00, 8'h7f, 8'h02, 1'b1, 1'b1}},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'h04, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b0, NO_RES},
		'{8'hff, 1'b1, 1'b1, '{KIND_PARAM, 8'hff, 8'h00, 8'hff, 8'h04, 1'b0, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{KIND_PARAM, 8'h00, 8'h01, 8'hff, 8'h04, 1'b0, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{KIND_END, 8'h00, 8'h00, 8'hff, 8'h04, 1'b0, 1'b1}},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'hff, 1'b0, 1'b0, NO_RES},
		'{8'h03, 1'b0, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b0, NO_RES},
		'{8'ha5, 1'b0, 1'b0, NO_RES},
		'{8'h57, 1'b0, 1'b0, NO_RES}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       kind;
	logic [7:0] param_byte;
	logic [7:0] param_index;
	logic [7:0] opcode;
	logic [7:0] frame_length;
	logic       checksum_ok;
	logic       last;

	srv_result_t results_due[$];
	logic [7:0]  packet_bytes[$];
	int          mismatches;
	int          long_frames;
	bit          in_calm;
	bit          out_calm;

	logic [PhaseWidth-1:0] rx_phase;
	logic [7:0]            rx_len;
	logic [7:0]            rx_count;
	logic [7:0]            rx_op;
	logic [7:0]            rx_sum;

	servo_packet_receiver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.param_byte  (param_byte),
		.param_index (param_index),
		.opcode      (opcode),
		.frame_length(frame_length),
		.checksum_ok (checksum_ok),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void deframe_byte(input logic [7:0] b, output bit got,
			output srv_result_t r);
		got = 1'b0;
		r = '0;
		case (rx_phase)
			PH_IDLE: begin
				if (b == SYNC_BYTE)
					rx_phase = PH_SYNC1;
			end
			PH_SYNC1: begin
				rx_phase = (b == SYNC_BYTE) ? PH_LEN : PH_IDLE;
			end
			PH_LEN: begin
				rx_len = b;
				rx_sum = b;
				rx_phase = (b == LEN_DROP || b < LEN_MIN) ? PH_IDLE : PH_INSTR;
			end
			PH_INSTR: begin
				rx_op = b;
				rx_sum = rx_sum + b;
				rx_count = 8'd0;
				rx_phase = PH_BODY;
			end
			PH_BODY: begin
				got = 1'b1;
				if ({1'b0, rx_count} + 9'd2 >= {1'b0, rx_len}) begin
					r = '{KIND_END, 8'h00, 8'h00, rx_op, rx_len, b == ~rx_sum, 1'b1};
					rx_phase = PH_IDLE;
				end else begin
					r = '{KIND_PARAM, b, rx_count, rx_op, rx_len, 1'b0, 1'b0};
					rx_sum = rx_sum + b;
					rx_count = rx_count + 8'd1;
				end
			end
			default: begin
				rx_phase = PH_IDLE;
			end
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic pinned, input logic has_res,
			input srv_result_t typed);
		int          gap;
		bit          got;
		srv_result_t r;
		if ($urandom_range(0, 31) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, MaxWait);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		deframe_byte(b, got, r);
		if (pinned) begin
			if (has_res)
				results_due.push_back(typed);
		end else if (got) begin
			results_due.push_back(r);
		end
		@(negedge clk);
	endtask

	task automatic make_packet(output int counted);
		int         roll;
		int         len;
		int         pick;
		logic [7:0] op;
		logic [7:0] p;
		logic [7:0] sum;
		packet_bytes.delete();
		counted = 0;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			repeat ($urandom_range(1, 4))
				packet_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (roll < 12) begin
			packet_bytes.push_back(SYNC_BYTE);
			packet_bytes.push_back(8'($urandom_range(0, 254)));
		end else if (roll < 16) begin
			pick = $urandom_range(0, 2);
			packet_bytes.push_back(SYNC_BYTE);
			packet_bytes.push_back(SYNC_BYTE);
			packet_bytes.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'h01 : LEN_DROP);
		end else begin
			if (long_frames < 3 && $urandom_range(0, 59) == 0) begin
				len = 254;
				long_frames++;
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(13, 253);
			end else begin
				len = $urandom_range(2, 12);
			end
			op = 8'($urandom_range(0, 255));
			sum = 8'(len) + op;
			packet_bytes.push_back(SYNC_BYTE);
			packet_bytes.push_back(SYNC_BYTE);
			packet_bytes.push_back(8'(len));
			packet_bytes.push_back(op);
			repeat (len - 2) begin
				p = 8'($urandom_range(0, 255));
				sum = sum + p;
				packet_bytes.push_back(p);
			end
			// mostly good checksums, some corrupted
			if ($urandom_range(0, 3) == 0)
				packet_bytes.push_back(8'($urandom_range(0, 255)));
			else
				packet_bytes.push_back(~sum);
			counted = packet_bytes.size();
		end
	endtask

	task automatic check_result();
		srv_result_t want;
		string       bad;
		if (results_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected transaction: kind=%0d byte=%02h idx=%0d op=%02h len=%0d ok=%0d last=%0d",
					kind, param_byte, param_index, opcode, frame_length, checksum_ok, last);
		end else begin
			want = results_due.pop_front();
			bad = "";
			if (kind !== want.kind)                 bad = {bad, " kind"};
			if (param_byte !== want.param_byte)     bad = {bad, " param_byte"};
			if (param_index !== want.param_index)   bad = {bad, " param_index"};
			if (opcode !== want.opcode)             bad = {bad, " opcode"};
			if (frame_length !== want.frame_length) bad = {bad, " frame_length"};
			if (checksum_ok !== want.checksum_ok)   bad = {bad, " checksum_ok"};
			if (last !== want.last)                 bad = {bad, " last"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch in%s", bad);
					$display("  expected kind=%0d byte=%02h idx=%0d op=%02h len=%0d ok=%0d last=%0d",
						want.kind, want.param_byte, want.param_index, want.opcode,
						want.frame_length, want.checksum_ok, want.last);
					$display("  actual   kind=%0d byte=%02h idx=%0d op=%02h len=%0d ok=%0d last=%0d",
						kind, param_byte, param_index, opcode, frame_length, checksum_ok, last);
				end
			end
		end
	endtask

	// result monitor
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				check_result();
		end
	end

	// receiver side stalls
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 31) == 0)
				out_calm = !out_calm;
			n = out_calm ? 0 : $urandom_range(0, MaxWait);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// watchdog on cycles with no transaction on either side
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("servo_packet_receiver regression: fail");
		$finish;
	end

	initial begin
		int sent;
		int counted;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		mismatches = 0;
		long_frames = 0;
		in_calm = 1'b0;
		out_calm = 1'b0;
		rx_phase = PH_IDLE;
		rx_len = 8'd0;
		rx_count = 8'd0;
		rx_op = 8'd0;
		rx_sum = 8'd0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].data, DIRECTED[i].pinned, DIRECTED[i].has_res,
				DIRECTED[i].res);

		sent = 0;
		while (sent < TargetBytes) begin
			make_packet(counted);
			sent += counted;
			foreach (packet_bytes[i])
				send_byte(packet_bytes[i], 1'b0, 1'b0, NO_RES);
		end
		in_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("servo_packet_receiver regression: pass");
		else
			$display("servo_packet_receiver regression: fail");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/srv_rx_pkg.sv
hw/rtl/srv_rx_deframer.sv
hw/rtl/servo_packet_receiver.sv
tb/tb_top.sv
